// ----- rtl/rabr_pkg.sv -----
`default_nettype none

package rabr_pkg;

    localparam logic [3:0] ALU_NONE = 4'd0;
    localparam logic [3:0] ALU_ADD  = 4'd1;
    localparam logic [3:0] ALU_SUB  = 4'd2;
    localparam logic [3:0] ALU_AND  = 4'd3;
    localparam logic [3:0] ALU_OR   = 4'd4;
    localparam logic [3:0] ALU_XOR  = 4'd5;
    localparam logic [3:0] ALU_SLL  = 4'd6;
    localparam logic [3:0] ALU_SRL  = 4'd7;
    localparam logic [3:0] ALU_SRA  = 4'd8;
    localparam logic [3:0] ALU_SLT  = 4'd9;
    localparam logic [3:0] ALU_SLTU = 4'd10;
    localparam logic [3:0] ALU_MAX  = ALU_SLTU;

    localparam logic [3:0] BR_NONE = 4'd0;
    localparam logic [3:0] BR_JAL  = 4'd1;
    localparam logic [3:0] BR_JALR = 4'd2;
    localparam logic [3:0] BR_BEQ  = 4'd3;
    localparam logic [3:0] BR_BNE  = 4'd4;
    localparam logic [3:0] BR_BLT  = 4'd5;
    localparam logic [3:0] BR_BGE  = 4'd6;
    localparam logic [3:0] BR_BLTU = 4'd7;
    localparam logic [3:0] BR_BGEU = 4'd8;
    localparam logic [3:0] BR_MAX  = BR_BGEU;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [3:0]  branch_kind;
        logic        first_from_pc;
        logic        first_from_index;
        logic        first_invert;
        logic        second_from_imm;
        logic [31:0] instr_pc;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
        logic [4:0]  src1_index;
        logic [31:0] immediate;
        logic [31:0] fetched_pc;
    } t_req;

    typedef struct packed {
        logic [31:0] dest_value;
        logic        is_branch;
        logic        taken;
        logic [31:0] next_pc;
        logic        mispredict;
        logic        illegal_op;
    } t_rsp;

    // branch status carried down the pipe
    typedef struct packed {
        logic is_branch;
        logic is_jump;
        logic taken;
        logic illegal;
    } t_br;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] seq_pc;
        logic [31:0] fetched_pc;
        t_br         br;
    } t_s1;

    typedef struct packed {
        logic [31:0] alu_res;
        logic [31:0] seq_pc;
        logic [31:0] fetched_pc;
        t_br         br;
    } t_s2;

endpackage

`default_nettype wire

// ----- rtl/rabr_opsel.sv -----
`default_nettype none

module rabr_opsel (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rabr_pkg::t_req i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rabr_pkg::t_s1      o_data
);

    logic          r_valid;
    rabr_pkg::t_s1 r_data;
    rabr_pkg::t_s1 n_data;
    logic [31:0]   a_sel;
    logic          illegal;
    logic          eq;
    logic          lt;
    logic          ltu;
    logic          cond;

    assign illegal = (i_data.req_type > rabr_pkg::ALU_MAX)
                   || (i_data.branch_kind > rabr_pkg::BR_MAX);
    assign eq  = i_data.src1_value == i_data.src2_value;
    assign lt  = $signed(i_data.src1_value) < $signed(i_data.src2_value);
    assign ltu = i_data.src1_value < i_data.src2_value;

    always_comb begin
        unique case (i_data.branch_kind)
            rabr_pkg::BR_JAL:  cond = 1'b1;
            rabr_pkg::BR_JALR: cond = 1'b1;
            rabr_pkg::BR_BEQ:  cond = eq;
            rabr_pkg::BR_BNE:  cond = !eq;
            rabr_pkg::BR_BLT:  cond = lt;
            rabr_pkg::BR_BGE:  cond = !lt;
            rabr_pkg::BR_BLTU: cond = ltu;
            rabr_pkg::BR_BGEU: cond = !ltu;
            default:           cond = 1'b0;
        endcase
    end

    always_comb begin
        priority if (i_data.first_from_pc) begin
            a_sel = i_data.instr_pc;
        end else if (i_data.first_from_index) begin
            a_sel = {27'd0, i_data.src1_index};
        end else begin
            a_sel = i_data.src1_value;
        end
        n_data.op         = illegal ? rabr_pkg::ALU_NONE : i_data.req_type;
        n_data.opa        = i_data.first_invert ? ~a_sel : a_sel;
        n_data.opb        = i_data.second_from_imm ? i_data.immediate : i_data.src2_value;
        n_data.seq_pc     = i_data.instr_pc + rabr_pkg::PC_STEP;
        n_data.fetched_pc = i_data.fetched_pc;
        n_data.br.illegal = illegal;
        n_data.br.is_branch = !illegal && (i_data.branch_kind != rabr_pkg::BR_NONE);
        n_data.br.is_jump = (i_data.branch_kind == rabr_pkg::BR_JAL)
                          || (i_data.branch_kind == rabr_pkg::BR_JALR);
        n_data.br.taken   = !illegal && cond;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/rabr_alu.sv -----
`default_nettype none

module rabr_alu (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rabr_pkg::t_s1 i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rabr_pkg::t_s2      o_data
);

    logic          r_valid;
    rabr_pkg::t_s2 r_data;
    rabr_pkg::t_s2 n_data;
    logic [4:0]    sh;
    logic [31:0]   res;

    assign sh = i_data.opb[4:0];

    always_comb begin
        unique case (i_data.op)
            rabr_pkg::ALU_ADD:  res = i_data.opa + i_data.opb;
            rabr_pkg::ALU_SUB:  res = i_data.opa - i_data.opb;
            rabr_pkg::ALU_AND:  res = i_data.opa & i_data.opb;
            rabr_pkg::ALU_OR:   res = i_data.opa | i_data.opb;
            rabr_pkg::ALU_XOR:  res = i_data.opa ^ i_data.opb;
            rabr_pkg::ALU_SLL:  res = i_data.opa << sh;
            rabr_pkg::ALU_SRL:  res = i_data.opa >> sh;
            rabr_pkg::ALU_SRA:  res = 32'($signed(i_data.opa) >>> sh);
            rabr_pkg::ALU_SLT:  res = {31'd0, $signed(i_data.opa) < $signed(i_data.opb)};
            rabr_pkg::ALU_SLTU: res = {31'd0, i_data.opa < i_data.opb};
            default:            res = 32'd0;
        endcase
    end

    always_comb begin
        n_data.alu_res    = res;
        n_data.seq_pc     = i_data.seq_pc;
        n_data.fetched_pc = i_data.fetched_pc;
        n_data.br         = i_data.br;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/rabr_resolve.sv -----
`default_nettype none

module rabr_resolve (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rabr_pkg::t_s2 i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rabr_pkg::t_rsp     o_data
);

    logic           r_valid;
    rabr_pkg::t_rsp r_data;
    rabr_pkg::t_rsp n_data;
    logic [31:0]    nxt;

    assign nxt = i_data.br.taken ? i_data.alu_res : i_data.seq_pc;

    always_comb begin
        n_data.dest_value = (i_data.br.taken && i_data.br.is_jump) ? i_data.seq_pc
                                                                   : i_data.alu_res;
        n_data.is_branch  = i_data.br.is_branch;
        n_data.taken      = i_data.br.taken;
        n_data.next_pc    = nxt;
        n_data.mispredict = i_data.br.is_branch && (nxt != i_data.fetched_pc);
        n_data.illegal_op = i_data.br.illegal;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/rv32i_alu_branch_resolve_unit.sv -----
// A request passes through operand select and compare, ALU and branch resolve
// stages in that order; each stage is registered.
// Throughput: one request per cycle while the output is not stalled; a stalled output holds each full stage in place.
// Reset (synchronous, active low) clears all stage valid bits; payload is not reset.
`default_nettype none

module rv32i_alu_branch_resolve_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire rabr_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output rabr_pkg::t_rsp      o_rsp
);

    logic          s1_valid;
    logic          s1_ready;
    rabr_pkg::t_s1 s1_data;
    logic          s2_valid;
    logic          s2_ready;
    rabr_pkg::t_s2 s2_data;

    rabr_opsel u_opsel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_data  (i_req),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    rabr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    rabr_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_data  (o_rsp)
    );

endmodule

`default_nettype wire
